// ----- rtl/first_fit_block_allocator_core_defines.svh -----
// ---------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared concurrent assertion shapes for the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FFBA_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ffba_pkg.sv -----
// ---------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator modules.
// ---------------------------------------------------------------------------
package ffba_pkg;

   // Default map geometry
   localparam int BLOCK_COUNT_DEF = 32;
   localparam int BLOCK_BYTES_DEF = 16;

   // Fixed payload widths
   localparam int COUNT_W   = 10;
   localparam int ADDR_W    = 9;
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   // Request action codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Sequencer states
   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_DIV_NEED  = 8'b0000_0100,
      ST_DIV_FIRST = 8'b0000_1000,
      ST_SCAN      = 8'b0001_0000,
      ST_MARK      = 8'b0010_0000,
      ST_FREE      = 8'b0100_0000,
      ST_DONE      = 8'b1000_0000
   } state_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- rtl/ffba_div.sv -----
// ---------------------------------------------------------------------------
// ffba_div
// Divider by the constant block size: a registered reciprocal multiply;
// the dividend is registered at start, then the quotient with the done flag.
// ---------------------------------------------------------------------------
module ffba_div
   import ffba_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   parameter int DIV_W       = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   output div_stat_type     status,
   output logic [DIV_W-1:0] quotient
);

   // Reciprocal exact for every dividend below 2**DIV_W
   localparam int SH = DIV_W + $clog2(BLOCK_BYTES);
   localparam int MW = SH + 1;
   localparam int PRW = DIV_W + MW;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + longint'(BLOCK_BYTES) - 64'd1) / longint'(BLOCK_BYTES);

   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic             pend_ff, pend_in;
   logic             done_ff, done_in;
   logic [PRW-1:0]   prod;

   // Multiply the held dividend by the scaled reciprocal
   assign prod = PRW'(dvd_ff) * PRW'(RECIP);

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      pend_in = 1'b0;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         pend_in = 1'b1;
      end else if (pend_ff) begin
         quo_in  = prod[SH +: DIV_W];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign status.busy = pend_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- rtl/ffba_map.sv -----
// ---------------------------------------------------------------------------
// ffba_map
// Block usage map: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ffba_map
   import ffba_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(BLOCK_COUNT)-1:0] wr_idx,
   input  logic                           wr_data,
   input  logic [$clog2(BLOCK_COUNT)-1:0] rd_idx,
   output logic                           rd_data
);

   logic mem_ff [BLOCK_COUNT];
   logic rd_data_ff;

   // Write one block flag; read one block flag into a register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/first_fit_block_allocator_core.sv -----
// Allocate: a zero or oversize size goes to the response right after the rounding divide; otherwise the map
//   is scanned until a free run of the needed length is found and marked, or the map ends.
// Free: a second divide finds the first block, then the released blocks are written free.
// One item at a time, the next accepted in the cycle after the response register loads;
//   the map port serves one block per cycle, and a held response stalls the sequencer.
// Reset: a clearing pass writes every map entry free, with ready low.
// ---------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit contiguous block allocator with a serial map scan and a shared
// constant divider for rounding byte counts and addresses to blocks.
// ---------------------------------------------------------------------------
`include "first_fit_block_allocator_core_defines.svh"

module first_fit_block_allocator_core
   import ffba_pkg::*;
#(
   parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [COUNT_W-1:0] req_byte_count,
   input  logic [ADDR_W-1:0] req_release_address,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_granted,
   output logic [ADDR_W-1:0] rsp_granted_address
);

   localparam int DIV_W = $clog2(COUNT_MAX + BLOCK_BYTES);
   localparam int NW    = $clog2(BLOCK_COUNT + 1);
   localparam int CW    = (DIV_W > NW) ? DIV_W : NW;
   localparam int IW    = $clog2(BLOCK_COUNT);
   localparam int PW    = CW + $clog2(BLOCK_BYTES + 1);

   state_type         state_ff, state_in;
   logic              action_ff, action_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DIV_W-1:0]  need_ff, need_in;
   logic [DIV_W-1:0]  left_ff, left_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     end_ff, end_in;
   logic [CW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     chk_idx_ff, chk_idx_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [CW-1:0]     run_len_ff, run_len_in;
   logic [CW-1:0]     run_start_ff, run_start_in;
   logic              res_granted_ff, res_granted_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_granted_ff, rsp_granted_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   div_stat_type      div_stat;
   logic [DIV_W-1:0]  div_quot;

   logic              map_wr_en;
   logic              map_wr_data;
   logic              map_rd_data;

   logic [CW-1:0]     scan_len;
   logic [CW-1:0]     scan_start;
   logic [PW-1:0]     addr_prod;
   logic              rsp_load;

   // Byte address of the run being marked
   assign addr_prod = PW'(run_start_ff) * PW'(BLOCK_BYTES);

   // Run tracking for the flag that arrives from the map this cycle
   assign scan_len   = run_len_ff + 1'b1;
   assign scan_start = (run_len_ff == '0) ? chk_idx_ff : run_start_ff;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      addr_in        = addr_ff;
      need_in        = need_ff;
      left_in        = left_ff;
      idx_in         = idx_ff;
      end_in         = end_ff;
      rd_ptr_in      = rd_ptr_ff;
      chk_idx_in     = chk_idx_ff;
      chk_vld_in     = 1'b0;
      run_len_in     = run_len_ff;
      run_start_in   = run_start_ff;
      res_granted_in = res_granted_ff;
      res_addr_in    = res_addr_ff;
      div_start      = 1'b0;
      div_dividend   = DIV_W'(req_byte_count) + DIV_W'(BLOCK_BYTES - 1);
      map_wr_en      = 1'b0;
      map_wr_data    = 1'b0;
      rsp_load       = 1'b0;

      case (state_ff)
         // Sweep the map free after reset
         ST_CLEAR: begin
            map_wr_en = 1'b1;
            if (idx_ff == CW'(BLOCK_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Take an item and round its byte count to blocks
         ST_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               addr_in   = req_release_address;
               div_start = 1'b1;
               state_in  = ST_DIV_NEED;
            end
         end

         ST_DIV_NEED: begin
            if (div_stat.done) begin
               need_in = div_quot;
               if (action_ff == ACT_FREE) begin
                  div_dividend = DIV_W'(addr_ff) + DIV_W'(BLOCK_BYTES - 1);
                  div_start    = 1'b1;
                  state_in     = ST_DIV_FIRST;
               end else if (div_quot == '0 || CW'(div_quot) > CW'(BLOCK_COUNT)) begin
                  res_granted_in = 1'b0;
                  res_addr_in    = '0;
                  state_in       = ST_DONE;
               end else begin
                  rd_ptr_in  = '0;
                  run_len_in = '0;
                  state_in   = ST_SCAN;
               end
            end
         end

         // First block boundary at or after the release address
         ST_DIV_FIRST: begin
            if (div_stat.done) begin
               idx_in   = CW'(div_quot);
               left_in  = need_ff;
               state_in = ST_FREE;
            end
         end

         // Issue one map read per cycle and check the flag from the cycle before
         ST_SCAN: begin
            if (rd_ptr_ff < CW'(BLOCK_COUNT)) begin
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               chk_idx_in = rd_ptr_ff;
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff) begin
               if (map_rd_data) begin
                  run_len_in = '0;
               end else begin
                  run_len_in   = scan_len;
                  run_start_in = scan_start;
               end
               if (!map_rd_data && scan_len == CW'(need_ff)) begin
                  idx_in     = scan_start;
                  end_in     = chk_idx_ff;
                  chk_vld_in = 1'b0;
                  state_in   = ST_MARK;
               end else if (chk_idx_ff == CW'(BLOCK_COUNT - 1)) begin
                  res_granted_in = 1'b0;
                  res_addr_in    = '0;
                  chk_vld_in     = 1'b0;
                  state_in       = ST_DONE;
               end
            end
         end

         // Mark the found run allocated, one block per cycle
         ST_MARK: begin
            map_wr_en   = 1'b1;
            map_wr_data = 1'b1;
            if (idx_ff == end_ff) begin
               res_granted_in = 1'b1;
               res_addr_in    = addr_prod[ADDR_W-1:0];
               state_in       = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Release blocks until the count runs out or the map ends
         ST_FREE: begin
            if (left_ff == '0 || idx_ff >= CW'(BLOCK_COUNT)) begin
               res_granted_in = 1'b1;
               res_addr_in    = '0;
               state_in       = ST_DONE;
            end else begin
               map_wr_en = 1'b1;
               idx_in    = idx_ff + 1'b1;
               left_in   = left_ff - 1'b1;
            end
         end

         // Hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_granted_in = rsp_granted_ff;
      rsp_addr_in    = rsp_addr_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = res_granted_ff;
         rsp_addr_in    = res_addr_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff      <= action_in;
      addr_ff        <= addr_in;
      need_ff        <= need_in;
      left_ff        <= left_in;
      end_ff         <= end_in;
      rd_ptr_ff      <= rd_ptr_in;
      chk_idx_ff     <= chk_idx_in;
      run_len_ff     <= run_len_in;
      run_start_ff   <= run_start_in;
      res_granted_ff <= res_granted_in;
      res_addr_ff    <= res_addr_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_addr_ff    <= rsp_addr_in;
   end

   ffba_div #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .DIV_W       (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .status   (div_stat),
      .quotient (div_quot)
   );

   ffba_map #(
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_idx  (idx_ff[IW-1:0]),
      .wr_data (map_wr_data),
      .rd_idx  (rd_ptr_ff[IW-1:0]),
      .rd_data (map_rd_data)
   );

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted         = rsp_granted_ff;
   assign rsp_granted_address = rsp_addr_ff;

   // Checks
   `FFBA_ASSERT_HOLDS(a_fail_addr_zero, clock, reset, rsp_valid_ff && !rsp_granted_ff, rsp_addr_ff == '0, "failed item carries a nonzero address")
   `FFBA_ASSERT_HOLDS(a_div_in_div_state, clock, reset, div_stat.busy, state_ff == ST_DIV_NEED || state_ff == ST_DIV_FIRST, "divider busy outside a divide state")
   `FFBA_ASSERT_HOLDS(a_mark_in_run, clock, reset, state_ff == ST_MARK, idx_ff <= end_ff, "mark index ran past the run end")
   `FFBA_ASSERT_HOLDS(a_scan_below_need, clock, reset, state_ff == ST_SCAN, run_len_ff < CW'(need_ff), "scan run reached the need without a hit")
   `FFBA_ASSERT_NEXT(a_accept_divides, clock, reset, req_valid && req_ready, state_ff == ST_DIV_NEED && div_stat.busy, "accepted item did not start the divider")

endmodule
